[rtl/core/rpzb_pkg.sv]
// Package: frame geometry, sine table, command codes and transaction types.
`timescale 1ns / 1ps
package rpzb_pkg;

   localparam int COLUMNS     = 160;
   localparam int ROWS        = 44;
   localparam int ANGLE_STEPS = 1024;
   localparam int QUARTER     = ANGLE_STEPS / 4;
   localparam int TURN        = 4 * QUARTER;
   localparam int CELLS       = COLUMNS * ROWS;
   localparam int CELL_W      = $clog2(CELLS);
   localparam int ANGLE_W     = $clog2(TURN);
   localparam int QUARTER_W   = $clog2(QUARTER);
   localparam int CFG_W       = 10;
   localparam int OOZ_W       = 24;
   localparam int ZT_W        = 25;
   localparam int SAT_LIMIT   = 16384;

   localparam longint unsigned ONE_Q30     = 64'd1073741824;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [1:0] {
      CMD_PLOT  = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_ANGLE_A    = 3'd0,
      CSR_ANGLE_B    = 3'd1,
      CSR_ANGLE_C    = 3'd2,
      CSR_CAMERA     = 3'd3,
      CSR_FOCAL      = 3'd4,
      CSR_COL_OFFSET = 3'd5,
      CSR_BACKGROUND = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [1:0]          cmd;
      logic signed [7:0]   point_i;
      logic signed [7:0]   point_j;
      logic signed [7:0]   point_k;
      logic [7:0]          glyph_in;
      logic [CELL_W-1:0]   read_index;
   } req_type;

   typedef struct packed {
      logic                plotted;
      logic [CELL_W-1:0]   cell_index;
      logic [7:0]          glyph_out;
   } rsp_type;

   typedef struct packed {
      logic                done;
      logic [OOZ_W-1:0]    ooz;
   } recip_result_type;

   typedef logic [QUARTER:0][14:0] sine_tab_type;

   // Quarter-wave entry, Taylor series in Q30, rounded to Q14
   function automatic logic [14:0] rom_entry(int unsigned q);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned s;
      longint unsigned r;
      x  = longint'(q) * HALF_PI_Q30 / QUARTER;
      x2 = (x * x) >> 30;
      t  = ONE_Q30 - x2 / 110;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      r  = (s + 64'd32768) >> 16;
      if (r > 64'd16384) begin
         r = 64'd16384;
      end
      return r[14:0];
   endfunction

   function automatic sine_tab_type build_sine_tab();
      sine_tab_type tab;
      for (int q = 0; q <= QUARTER; q++) begin
         tab[q] = rom_entry(q);
      end
      return tab;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine_tab();

   function automatic logic signed [15:0] sine_q14(logic [ANGLE_W-1:0] p);
      logic [1:0]           quad;
      logic [QUARTER_W-1:0] r;
      logic [QUARTER_W:0]   ti;
      logic [14:0]          v;
      quad = p[ANGLE_W-1 -: 2];
      r    = p[QUARTER_W-1:0];
      ti   = quad[0] ? ((QUARTER_W + 1)'(QUARTER) - {1'b0, r}) : {1'b0, r};
      v    = SINE_TAB[ti];
      return quad[1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
   endfunction

endpackage

[rtl/core/rpzb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rpzb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/rpzb_recip.sv]
// Radix-4 restoring divider forming floor(2^38 / zt) for zt above 2^14.
`timescale 1ns / 1ps
module rpzb_recip (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rpzb_pkg::ZT_W-1:0]     divisor,
   output rpzb_pkg::recip_result_type    result
);

   localparam int STEPS = rpzb_pkg::OOZ_W / 2;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic [rpzb_pkg::ZT_W-1:0]  rem_ff, rem_in;
   logic [rpzb_pkg::ZT_W-1:0]  div_ff;
   logic [rpzb_pkg::OOZ_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       done_ff, done_in;

   always_comb begin
      logic [rpzb_pkg::ZT_W:0] t;
      t        = '0;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      if (start) begin
         // numerator bits above the quotient are 2^14, already below zt
         rem_in   = rpzb_pkg::ZT_W'(rpzb_pkg::SAT_LIMIT);
         quo_in   = '0;
         count_in = CNT_W'(STEPS);
      end else if (count_ff != '0) begin
         for (int s = 0; s < 2; s++) begin
            t = {rem_in, 1'b0};
            if (t >= {1'b0, div_ff}) begin
               rem_in = rpzb_pkg::ZT_W'(t - {1'b0, div_ff});
               quo_in = {quo_in[rpzb_pkg::OOZ_W-2:0], 1'b1};
            end else begin
               rem_in = t[rpzb_pkg::ZT_W-1:0];
               quo_in = {quo_in[rpzb_pkg::OOZ_W-2:0], 1'b0};
            end
         end
         count_in = count_ff - 1'b1;
         done_in  = (count_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         div_ff <= divisor;
      end
   end

   assign result.done = done_ff;
   assign result.ooz  = quo_ff;

endmodule

[rtl/core/rotate_project_zbuffer_plot.sv]
// Top level: rotate, project and depth-test points into a glyph frame.
// Plot: ROT, CHECK, the radix-4 divider wait, MUL1, MUL2, PROJ, INDEX, READ, then the strobe;
//   a point leaving the frame ends at INDEX, a very near one skips the divider wait and one
//   behind the camera ends at CHECK. Read: INDEX then READ, or INDEX alone when out of range.
// Clear: every cell in turn. Unused command: next cycle. One transaction at a time; the
// receiver cannot stall, so nothing waits on the output. Reset: busy stays high through a
// clearing pass of the frame RAMs. A register write holds busy while the rotation matrix settles.
`timescale 1ns / 1ps
module rotate_project_zbuffer_plot (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  rpzb_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   output rpzb_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [2:0]                           csr_index,
   input  logic [rpzb_pkg::CFG_W-1:0]           csr_wdata
);

   localparam int CW = rpzb_pkg::CELL_W;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_CLEAR = 10'b0000000010,
      ST_ROT   = 10'b0000000100,
      ST_CHECK = 10'b0000001000,
      ST_DIV   = 10'b0000010000,
      ST_MUL1  = 10'b0000100000,
      ST_MUL2  = 10'b0001000000,
      ST_PROJ  = 10'b0010000000,
      ST_INDEX = 10'b0100000000,
      ST_READ  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] settle_ff, settle_in;
   logic [CW-1:0] clr_addr_ff, clr_addr_in;
   logic clr_reply_ff, clr_reply_in;
   logic rsp_valid_ff, rsp_valid_in;
   rpzb_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // configuration
   logic [rpzb_pkg::ANGLE_W-1:0] angle_a_ff, angle_b_ff, angle_c_ff;
   logic [7:0] camera_ff, focal_ff, background_ff;
   logic signed [7:0] col_offset_ff;

   // rotation matrix pipeline, follows the configuration
   logic signed [15:0] sa_ff, ca_ff, sb_ff, cb_ff, sc_ff, cc_ff;
   logic signed [31:0] sasb_ff, casb_ff, casc_ff, sasc_ff, cbcc_ff;
   logic signed [31:0] cacc_ff, sacc_ff, cbsc_ff, cacb_ff, sacb_ff;
   logic signed [15:0] sb2_ff, sc2_ff, cc2_ff;
   logic signed [45:0] mxj_ff, mxk_ff, mxi_ff, myj_ff, myk_ff, myi_ff;
   logic signed [45:0] mzj_ff, mzk_ff, mzi_ff;

   // per-transaction datapath
   rpzb_pkg::req_type req_ff;
   logic signed [25:0] xq_ff, yq_ff;
   logic signed [26:0] zt_ff;
   logic [rpzb_pkg::OOZ_W-1:0] ooz_ff, ooz_in;
   logic [31:0] m_ff;
   logic signed [58:0] px_ff, py_ff;
   logic signed [22:0] col_ff, row_ff;
   logic [CW-1:0] idx_ff, idx_in;

   logic signed [55:0] xs, ys, zs;
   logic signed [26:0] zt_c;
   logic signed [58:0] px_c, py_c;
   logic signed [15:0] base_x;
   logic signed [60:0] cx, cy, cxa, cya;
   logic signed [32:0] idx_c;
   logic idx_ok;

   logic mem_we;
   logic [CW-1:0] mem_waddr, mem_raddr;
   logic [7:0] glyph_wdata, glyph_rd;
   logic [rpzb_pkg::OOZ_W-1:0] depth_wdata, depth_rd;
   logic div_start;
   rpzb_pkg::recip_result_type div_res;
   logic accept;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE) || (settle_ff != '0);

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_a_ff    <= '0;
         angle_b_ff    <= '0;
         angle_c_ff    <= '0;
         camera_ff     <= 8'd100;
         focal_ff      <= 8'd40;
         col_offset_ff <= -8'sd40;
         background_ff <= 8'd46;
      end else if (csr_we) begin
         unique case (csr_index)
            rpzb_pkg::CSR_ANGLE_A:    angle_a_ff    <= rpzb_pkg::ANGLE_W'(csr_wdata);
            rpzb_pkg::CSR_ANGLE_B:    angle_b_ff    <= rpzb_pkg::ANGLE_W'(csr_wdata);
            rpzb_pkg::CSR_ANGLE_C:    angle_c_ff    <= rpzb_pkg::ANGLE_W'(csr_wdata);
            rpzb_pkg::CSR_CAMERA:     camera_ff     <= csr_wdata[7:0];
            rpzb_pkg::CSR_FOCAL:      focal_ff      <= csr_wdata[7:0];
            rpzb_pkg::CSR_COL_OFFSET: col_offset_ff <= $signed(csr_wdata[7:0]);
            rpzb_pkg::CSR_BACKGROUND: background_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // three register stages from angles to the Q42 matrix
   always_ff @(posedge clock) begin
      sa_ff <= rpzb_pkg::sine_q14(angle_a_ff);
      ca_ff <= rpzb_pkg::sine_q14(angle_a_ff + rpzb_pkg::ANGLE_W'(rpzb_pkg::QUARTER));
      sb_ff <= rpzb_pkg::sine_q14(angle_b_ff);
      cb_ff <= rpzb_pkg::sine_q14(angle_b_ff + rpzb_pkg::ANGLE_W'(rpzb_pkg::QUARTER));
      sc_ff <= rpzb_pkg::sine_q14(angle_c_ff);
      cc_ff <= rpzb_pkg::sine_q14(angle_c_ff + rpzb_pkg::ANGLE_W'(rpzb_pkg::QUARTER));

      sasb_ff <= 32'(sa_ff) * 32'(sb_ff);
      casb_ff <= 32'(ca_ff) * 32'(sb_ff);
      casc_ff <= 32'(ca_ff) * 32'(sc_ff);
      sasc_ff <= 32'(sa_ff) * 32'(sc_ff);
      cbcc_ff <= 32'(cb_ff) * 32'(cc_ff);
      cacc_ff <= 32'(ca_ff) * 32'(cc_ff);
      sacc_ff <= 32'(sa_ff) * 32'(cc_ff);
      cbsc_ff <= 32'(cb_ff) * 32'(sc_ff);
      cacb_ff <= 32'(ca_ff) * 32'(cb_ff);
      sacb_ff <= 32'(sa_ff) * 32'(cb_ff);
      sb2_ff  <= sb_ff;
      sc2_ff  <= sc_ff;
      cc2_ff  <= cc_ff;

      mxj_ff <= 46'(sasb_ff) * 46'(cc2_ff) + (46'(casc_ff) <<< 14);
      mxk_ff <= (46'(sasc_ff) <<< 14) - 46'(casb_ff) * 46'(cc2_ff);
      mxi_ff <= 46'(cbcc_ff) <<< 14;
      myj_ff <= (46'(cacc_ff) <<< 14) - 46'(sasb_ff) * 46'(sc2_ff);
      myk_ff <= (46'(sacc_ff) <<< 14) + 46'(casb_ff) * 46'(sc2_ff);
      myi_ff <= -(46'(cbsc_ff) <<< 14);
      mzj_ff <= -(46'(sacb_ff) <<< 14);
      mzk_ff <= 46'(cacb_ff) <<< 14;
      mzi_ff <= 46'(sb2_ff) <<< 28;
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      xs = 56'(req_ff.point_j) * 56'(mxj_ff) + 56'(req_ff.point_k) * 56'(mxk_ff)
         + 56'(req_ff.point_i) * 56'(mxi_ff);
      ys = 56'(req_ff.point_j) * 56'(myj_ff) + 56'(req_ff.point_k) * 56'(myk_ff)
         + 56'(req_ff.point_i) * 56'(myi_ff);
      zs = 56'(req_ff.point_j) * 56'(mzj_ff) + 56'(req_ff.point_k) * 56'(mzk_ff)
         + 56'(req_ff.point_i) * 56'(mzi_ff);
      // arithmetic shift floors Q42 to Q14
      zt_c = $signed(zs[54:28]) + $signed({5'b0, camera_ff, 14'b0});

      px_c = $signed({1'b0, m_ff}) * xq_ff;
      py_c = $signed({1'b0, m_ff}) * yq_ff;

      base_x = 16'(rpzb_pkg::COLUMNS / 2) + 16'(col_offset_ff);
      cx  = (61'(base_x) <<< 38) + (61'(px_ff) <<< 1);
      cy  = (61'(rpzb_pkg::ROWS / 2) <<< 38) + 61'(py_ff);
      // bias negatives so the shift truncates toward zero
      cxa = cx + $signed({23'b0, {38{cx[60]}}});
      cya = cy + $signed({23'b0, {38{cy[60]}}});

      idx_c  = 33'(col_ff) + 33'(row_ff) * 33'(rpzb_pkg::COLUMNS);
      idx_ok = (idx_c >= 0) && (idx_c < 33'(rpzb_pkg::CELLS));
   end

   assign div_start = (state_ff == ST_CHECK) && !zt_ff[26]
                      && (zt_ff > 27'(rpzb_pkg::SAT_LIMIT));

   rpzb_recip u_recip (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .divisor (zt_ff[rpzb_pkg::ZT_W-1:0]),
      .result  (div_res)
   );

   // ---------------------------------------------------------------- control
   always_comb begin
      state_in     = state_ff;
      settle_in    = settle_ff;
      clr_addr_in  = clr_addr_ff;
      clr_reply_in = clr_reply_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = '0;
      ooz_in       = ooz_ff;
      idx_in       = idx_ff;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff;
      mem_raddr    = idx_ff;
      glyph_wdata  = req_ff.glyph_in;
      depth_wdata  = ooz_ff;

      if (csr_we) begin
         settle_in = 2'd3;
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.cmd)
                  rpzb_pkg::CMD_PLOT:  state_in = ST_ROT;
                  rpzb_pkg::CMD_READ:  state_in = ST_INDEX;
                  rpzb_pkg::CMD_CLEAR: begin
                     state_in     = ST_CLEAR;
                     clr_addr_in  = '0;
                     clr_reply_in = 1'b1;
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            glyph_wdata = background_ff;
            depth_wdata = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == CW'(rpzb_pkg::CELLS - 1)) begin
               rsp_valid_in = clr_reply_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_ROT: state_in = ST_CHECK;
         ST_CHECK: begin
            if (zt_ff[26] || (zt_ff == '0)) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (div_start) begin
               state_in = ST_DIV;
            end else begin
               ooz_in   = '1;
               state_in = ST_MUL1;
            end
         end
         ST_DIV: begin
            if (div_res.done) begin
               ooz_in   = div_res.ooz;
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_PROJ;
         ST_PROJ: state_in = ST_INDEX;
         ST_INDEX: begin
            if (req_ff.cmd == rpzb_pkg::CMD_READ) begin
               if (req_ff.read_index < CW'(rpzb_pkg::CELLS)) begin
                  mem_raddr = req_ff.read_index;
                  idx_in    = req_ff.read_index;
                  state_in  = ST_READ;
               end else begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (idx_ok) begin
               mem_raddr = idx_c[CW-1:0];
               idx_in    = idx_c[CW-1:0];
               state_in  = ST_READ;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_READ: begin
            rsp_valid_in           = 1'b1;
            rsp_data_in.cell_index = idx_ff;
            if (req_ff.cmd == rpzb_pkg::CMD_READ) begin
               rsp_data_in.glyph_out = glyph_rd;
            end else if (ooz_ff > depth_rd) begin
               mem_we              = 1'b1;
               rsp_data_in.plotted = 1'b1;
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         settle_ff    <= '0;
         clr_addr_ff  <= '0;
         clr_reply_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         settle_ff    <= settle_in;
         clr_addr_ff  <= clr_addr_in;
         clr_reply_ff <= clr_reply_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (state_ff == ST_ROT) begin
         xq_ff <= $signed(xs[53:28]);
         yq_ff <= $signed(ys[53:28]);
         zt_ff <= zt_c;
      end
      ooz_ff      <= ooz_in;
      m_ff        <= 32'(focal_ff) * 32'(ooz_ff);
      px_ff       <= px_c;
      py_ff       <= py_c;
      col_ff      <= $signed(cxa[60:38]);
      row_ff      <= $signed(cya[60:38]);
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   rpzb_ram #(.WIDTH(8), .DEPTH(rpzb_pkg::CELLS)) u_glyph_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (glyph_wdata),
      .raddr (mem_raddr),
      .rdata (glyph_rd)
   );

   rpzb_ram #(.WIDTH(rpzb_pkg::OOZ_W), .DEPTH(rpzb_pkg::CELLS)) u_depth_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (depth_wdata),
      .raddr (mem_raddr),
      .rdata (depth_rd)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------- checks
   // an unused command is answered at once instead of raising busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_valid_ff))
      else $error("busy low after accepting a transaction");

   a_write_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (mem_waddr < CW'(rpzb_pkg::CELLS)))
      else $error("frame write out of range");

   a_plot_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.plotted) |-> $past(state_ff == ST_READ))
      else $error("plotted strobe without a depth compare");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside its wait state");

endmodule

[sim/testbench.sv]
// Testbench: rotate/project/depth-buffer plot block against a behavioural frame model.
`timescale 1ns / 1ps
module testbench;

   localparam int  CYCLE_LIMIT = 2000000;
   localparam int  DRAIN_WAIT  = 40;
   localparam int  RAND_PHASES = 9;
   localparam int  PHASE_ITEMS = 100;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   rpzb_pkg::req_type          req_data;
   logic                       rsp_valid;
   rpzb_pkg::rsp_type          rsp_data;
   logic                       csr_we;
   logic [2:0]                 csr_index;
   logic [rpzb_pkg::CFG_W-1:0] csr_wdata;

   rotate_project_zbuffer_plot DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // frame model state and register copies
   int          sin_rom [0:rpzb_pkg::QUARTER];
   logic [7:0]  frame_glyph [0:rpzb_pkg::CELLS-1];
   logic [23:0] frame_depth [0:rpzb_pkg::CELLS-1];
   logic [9:0]  rot_a, rot_b, rot_c;
   int          cam_dist, focal, col_shift, bg_glyph;

   rpzb_pkg::rsp_type pending_rsp [$];
   int          mismatches;
   int          cycles;
   int          n_plots, n_written, n_reads, n_clears, n_culled;
   bit          gaps_on;

   function automatic int quarter_sine(int unsigned q);
      longint unsigned x, x2, t, s, r;
      x  = longint'(q) * 64'd1686629713 / rpzb_pkg::QUARTER;
      x2 = (x * x) >> 30;
      t  = 64'd1073741824 - x2 / 110;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 72;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 42;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 20;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      r  = (s + 64'd32768) >> 16;
      return (r > 64'd16384) ? 16384 : int'(r);
   endfunction

   function automatic longint sin_of(int unsigned ang);
      int unsigned p, quad, r, v;
      p    = ang % rpzb_pkg::TURN;
      quad = p / rpzb_pkg::QUARTER;
      r    = p % rpzb_pkg::QUARTER;
      v    = (quad & 1) ? sin_rom[rpzb_pkg::QUARTER - r] : sin_rom[r];
      return (quad >= 2) ? -longint'(v) : longint'(v);
   endfunction

   // Works out the response and updates the frame for one accepted transaction
   function automatic rpzb_pkg::rsp_type frame_step(rpzb_pkg::req_type rq);
      rpzb_pkg::rsp_type res;
      longint  i, j, k, sa, ca, sb, cb, sc, cc, xq, yq, zq, ooz, cx, cy, col, row, idx;
      res = '0;
      if (rq.cmd == rpzb_pkg::CMD_CLEAR) begin
         for (int n = 0; n < rpzb_pkg::CELLS; n++) begin
            frame_glyph[n] = bg_glyph[7:0];
            frame_depth[n] = '0;
         end
         n_clears++;
      end else if (rq.cmd == rpzb_pkg::CMD_READ) begin
         n_reads++;
         if (rq.read_index < rpzb_pkg::CELLS) begin
            res.cell_index = rq.read_index;
            res.glyph_out  = frame_glyph[rq.read_index];
         end
      end else if (rq.cmd == rpzb_pkg::CMD_PLOT) begin
         n_plots++;
         i  = rq.point_i;
         j  = rq.point_j;
         k  = rq.point_k;
         sa = sin_of(rot_a); ca = sin_of(rot_a + rpzb_pkg::QUARTER);
         sb = sin_of(rot_b); cb = sin_of(rot_b + rpzb_pkg::QUARTER);
         sc = sin_of(rot_c); cc = sin_of(rot_c + rpzb_pkg::QUARTER);
         xq = j*sa*sb*cc - k*ca*sb*cc + (j*ca*sc + k*sa*sc + i*cb*cc) * 16384;
         yq = (j*ca*cc + k*sa*cc - i*cb*sc) * 16384 - j*sa*sb*sc + k*ca*sb*sc;
         zq = (k*ca*cb - j*sa*cb) * 16384 + i*sb*268435456;
         xq = xq >>> 28;
         yq = yq >>> 28;
         zq = (zq >>> 28) + longint'(cam_dist) * 16384;
         if (zq <= 0) begin
            n_culled++;
            return res;
         end
         ooz = (longint'(1) << 38) / zq;
         if (ooz > 64'hFFFFFF) ooz = 64'hFFFFFF;
         cx  = longint'(rpzb_pkg::COLUMNS/2 + col_shift) * (longint'(1) << 38)
               + longint'(focal) * ooz * xq * 2;
         cy  = longint'(rpzb_pkg::ROWS/2) * (longint'(1) << 38)
               + longint'(focal) * ooz * yq;
         col = cx / (longint'(1) << 38);
         row = cy / (longint'(1) << 38);
         idx = col + row * rpzb_pkg::COLUMNS;
         if (idx < 0 || idx >= rpzb_pkg::CELLS) begin
            n_culled++;
            return res;
         end
         res.cell_index = idx[rpzb_pkg::CELL_W-1:0];
         if (ooz[23:0] > frame_depth[idx]) begin
            frame_depth[idx] = ooz[23:0];
            frame_glyph[idx] = rq.glyph_in;
            res.plotted = 1'b1;
            n_written++;
         end
      end
      return res;
   endfunction

   task automatic wait_idle();
      while (pending_rsp.size() != 0 || busy) @(negedge clock);
   endtask

   task automatic csr_write(rpzb_pkg::csr_index_type idx, int value);
      wait_idle();
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = rpzb_pkg::CFG_W'(value);
      @(posedge clock);
      case (idx)
         rpzb_pkg::CSR_ANGLE_A:    rot_a = value[9:0];
         rpzb_pkg::CSR_ANGLE_B:    rot_b = value[9:0];
         rpzb_pkg::CSR_ANGLE_C:    rot_c = value[9:0];
         rpzb_pkg::CSR_CAMERA:     cam_dist = value & 8'hFF;
         rpzb_pkg::CSR_FOCAL:      focal = value & 8'hFF;
         rpzb_pkg::CSR_COL_OFFSET: col_shift = int'($signed(value[7:0]));
         rpzb_pkg::CSR_BACKGROUND: bg_glyph = value & 8'hFF;
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic configure(int a, int b, int c, int cam, int foc, int offs, int bg);
      csr_write(rpzb_pkg::CSR_ANGLE_A, a);
      csr_write(rpzb_pkg::CSR_ANGLE_B, b);
      csr_write(rpzb_pkg::CSR_ANGLE_C, c);
      csr_write(rpzb_pkg::CSR_CAMERA, cam);
      csr_write(rpzb_pkg::CSR_FOCAL, foc);
      csr_write(rpzb_pkg::CSR_COL_OFFSET, offs);
      csr_write(rpzb_pkg::CSR_BACKGROUND, bg);
   endtask

   // One transaction; a typed expectation overrides the model's answer
   task automatic issue(rpzb_pkg::req_type rq, bit typed, rpzb_pkg::rsp_type typed_rsp);
      rpzb_pkg::rsp_type predicted;
      if (gaps_on && $urandom_range(99) < 10) begin
         start = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      start    = 1'b1;
      req_data = rq;
      do @(posedge clock); while (busy);
      predicted = frame_step(rq);
      pending_rsp.push_back(typed ? typed_rsp : predicted);
      @(negedge clock);
      start = 1'b0;
   endtask

   function automatic rpzb_pkg::req_type make_req(logic [1:0] c, int pi, int pj, int pk,
                                                  int g, int ri);
      rpzb_pkg::req_type rq;
      rq.cmd        = c;
      rq.point_i    = pi[7:0];
      rq.point_j    = pj[7:0];
      rq.point_k    = pk[7:0];
      rq.glyph_in   = g[7:0];
      rq.read_index = ri[rpzb_pkg::CELL_W-1:0];
      return rq;
   endfunction

   function automatic rpzb_pkg::rsp_type make_rsp(bit p, int ci, int g);
      rpzb_pkg::rsp_type rs;
      rs.plotted    = p;
      rs.cell_index = ci[rpzb_pkg::CELL_W-1:0];
      rs.glyph_out  = g[7:0];
      return rs;
   endfunction

   function automatic rpzb_pkg::req_type random_req(bit allow_clear);
      int sel, span;
      logic [1:0] c;
      sel  = $urandom_range(99);
      span = ($urandom_range(3) == 0) ? 128 : 40;
      if (sel < 80)      c = rpzb_pkg::CMD_PLOT;
      else if (sel < 96) c = rpzb_pkg::CMD_READ;
      else if (sel < 98 || !allow_clear) c = 2'd3;
      else               c = rpzb_pkg::CMD_CLEAR;
      return make_req(c, $urandom_range(2*span-1) - span, $urandom_range(2*span-1) - span,
                      $urandom_range(2*span-1) - span, $urandom_range(255),
                      $urandom_range(8191));
   endfunction

   // response checker
   always @(posedge clock) begin
      rpzb_pkg::rsp_type want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("end of test: mismatches");
         $finish;
      end
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction: %p", rsp_data);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.plotted !== want.plotted || rsp_data.cell_index !== want.cell_index
                || rsp_data.glyph_out !== want.glyph_out) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected plotted=%0d idx=%0d glyph=%0d, got %0d %0d %0d",
                           want.plotted, want.cell_index, want.glyph_out,
                           rsp_data.plotted, rsp_data.cell_index, rsp_data.glyph_out);
            end
         end
      end
   end

   typedef struct {
      rpzb_pkg::req_type rq;
      bit                typed;
      rpzb_pkg::rsp_type rs;
   } vector_row;

   initial begin
      vector_row         vectors [$];
      rpzb_pkg::rsp_type none;
      none      = '0;
      mismatches = 0;
      cycles    = 0;
      n_plots = 0; n_written = 0; n_reads = 0; n_clears = 0; n_culled = 0;
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      reset     = 1'b1;
      gaps_on   = 1'b0;
      for (int q = 0; q <= rpzb_pkg::QUARTER; q++) sin_rom[q] = quarter_sine(q);
      for (int n = 0; n < rpzb_pkg::CELLS; n++) begin
         frame_glyph[n] = 8'd46;
         frame_depth[n] = '0;
      end
      rot_a = '0; rot_b = '0; rot_c = '0;
      cam_dist = 100; focal = 40; col_shift = -40; bg_glyph = 46;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table at reset configuration
      vectors.push_back('{make_req(rpzb_pkg::CMD_READ, 0, 0, 0, 0, 0), 1,
                          make_rsp(0, 0, 46)});
      vectors.push_back('{make_req(rpzb_pkg::CMD_READ, 0, 0, 0, 0, 7039), 1,
                          make_rsp(0, 7039, 46)});
      vectors.push_back('{make_req(rpzb_pkg::CMD_READ, 0, 0, 0, 0, 7040), 1, none});
      vectors.push_back('{make_req(rpzb_pkg::CMD_READ, 0, 0, 0, 0, 8191), 1, none});
      vectors.push_back('{make_req(2'd3, -1, -1, -1, 255, 8191), 1, none});
      vectors.push_back('{make_req(rpzb_pkg::CMD_PLOT, 0, 0, 0, 65, 0), 1,
                          make_rsp(1, 3560, 0)});
      vectors.push_back('{make_req(rpzb_pkg::CMD_PLOT, 0, 0, 0, 66, 0), 1,
                          make_rsp(0, 3560, 0)});
      vectors.push_back('{make_req(rpzb_pkg::CMD_READ, 0, 0, 0, 0, 3560), 1,
                          make_rsp(0, 3560, 65)});
      vectors.push_back('{make_req(rpzb_pkg::CMD_PLOT, 0, 0, -128, 1, 0), 1, none});
      vectors.push_back('{make_req(rpzb_pkg::CMD_PLOT, 0, 0, -100, 1, 0), 1, none});
      vectors.push_back('{make_req(rpzb_pkg::CMD_PLOT, 0, 0, -99, 90, 0), 0, none});
      vectors.push_back('{make_req(rpzb_pkg::CMD_PLOT, 0, 0, -90, 91, 0), 0, none});
      vectors.push_back('{make_req(rpzb_pkg::CMD_PLOT, 127, 127, 127, 255, 0), 0, none});
      vectors.push_back('{make_req(rpzb_pkg::CMD_PLOT, -128, -128, -128, 0, 0), 0, none});
      vectors.push_back('{make_req(rpzb_pkg::CMD_PLOT, 127, -128, 0, 170, 0), 0, none});
      vectors.push_back('{make_req(rpzb_pkg::CMD_PLOT, -128, 127, 127, 85, 0), 0, none});
      vectors.push_back('{make_req(rpzb_pkg::CMD_PLOT, 5, 3, 10, 67, 0), 0, none});
      vectors.push_back('{make_req(rpzb_pkg::CMD_PLOT, 5, 3, 20, 68, 0), 0, none});
      vectors.push_back('{make_req(rpzb_pkg::CMD_READ, 0, 0, 0, 0, 3560), 0, none});
      vectors.push_back('{make_req(rpzb_pkg::CMD_CLEAR, 0, 0, 0, 0, 0), 1, none});
      vectors.push_back('{make_req(rpzb_pkg::CMD_READ, 0, 0, 0, 0, 3560), 1,
                          make_rsp(0, 3560, 46)});
      vectors.push_back('{make_req(rpzb_pkg::CMD_PLOT, 0, 0, 0, 65, 0), 1,
                          make_rsp(1, 3560, 0)});
      foreach (vectors[n]) issue(vectors[n].rq, vectors[n].typed, vectors[n].rs);

      // random phases, the first ones at register extremes
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         case (ph)
            0: configure(1023, 1023, 1023, 1, 1, -128, 0);
            1: configure(0, 0, 0, 255, 255, 127, 255);
            2: configure(256, 512, 768, 200, 255, -128, 35);
            default: configure($urandom_range(1023), $urandom_range(1023),
                               $urandom_range(1023), $urandom_range(30, 255),
                               $urandom_range(1, 120), $urandom_range(255),
                               $urandom_range(255));
         endcase
         gaps_on = (ph != 4);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 5 && n == PHASE_ITEMS/2) wait_idle();
            issue(random_req(n % 50 == 25), 0, none);
         end
      end

      wait_idle();
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("covered %0d plots (%0d written, %0d culled), %0d reads, %0d clears",
               n_plots, n_written, n_culled, n_reads, n_clears);
      $display("over %0d register settings including extremes, %0d cycles",
               RAND_PHASES, cycles);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
